// ===== rtl/core/cdr_pkg.sv =====
package cdr_pkg;

    localparam int HDR_LEN         = 12;
    localparam int REC_LEN         = 16;
    localparam int IDX_W           = 4;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [IDX_W-1:0] HDR_FLAGS_IDX   = 4'd2;
    localparam logic [IDX_W-1:0] HDR_ANCOUNT_HI  = 4'd6;
    localparam logic [IDX_W-1:0] HDR_ANCOUNT_LO  = 4'd7;
    localparam logic [IDX_W-1:0] HDR_LAST_IDX    = 4'(HDR_LEN - 1);
    localparam logic [IDX_W-1:0] REC_LAST_IDX    = 4'(REC_LEN - 1);
    localparam logic [7:0]       QR_BIT          = 8'h80;

    typedef struct packed {
        logic       flush;
        logic       last;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic hdr_busy;
        logic collecting;
    } front_status_t;

    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                            input logic [7:0] b);
        logic [7:0] r;
        r = b;
        unique case (idx)
            HDR_FLAGS_IDX:  r = b | QR_BIT;
            HDR_ANCOUNT_HI: r = 8'h00;
            HDR_ANCOUNT_LO: r = 8'h01;
            default:        r = b;
        endcase
        return r;
    endfunction

    // A record: name ptr C0 0C, type A, class IN, TTL 0, rdlength 4, address
    function automatic logic [7:0] rec_byte(input logic [IDX_W-1:0] idx,
                                            input logic [31:0] ip);
        logic [7:0] r;
        r = 8'h00;
        unique case (idx)
            4'd0:    r = 8'hC0;
            4'd1:    r = 8'h0C;
            4'd3:    r = 8'h01;
            4'd5:    r = 8'h01;
            4'd11:   r = 8'h04;
            4'd12:   r = ip[31:24];
            4'd13:   r = ip[23:16];
            4'd14:   r = ip[15:8];
            4'd15:   r = ip[7:0];
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/cdr_if.sv =====
interface cdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface cdr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface cdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] answer_ipv4_address;

    modport source (output valid, output answer_ipv4_address, input ready);
    modport sink   (input valid, input answer_ipv4_address, output ready);
endinterface

// ===== rtl/core/cdr_front.sv =====
module cdr_front
    import cdr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    cdr_in_if.sink                     in_ch,
    input  logic                       q_full,
    output logic                       q_push,
    output cmd_t                       q_cmd,
    input  logic                       hdr_release,
    output logic [HDR_LEN-1:0][7:0]    hdr,
    output front_status_t              status
);

    localparam logic [1:0] MODE_COLLECT = 2'd0;
    localparam logic [1:0] MODE_PASS    = 2'd1;
    localparam logic [1:0] MODE_DROP    = 2'd2;

    logic [1:0]             mode_reg, mode_next;
    logic [IDX_W-1:0]       pos_reg, pos_next;
    logic                   hdr_busy_reg, hdr_busy_next;
    logic [HDR_LEN-1:0][7:0] hdr_reg;

    logic             accept;
    logic             collecting;
    logic [IDX_W-1:0] pos_eff;
    logic             hdr_ok;

    assign collecting  = (mode_reg == MODE_COLLECT);
    assign in_ch.ready = !q_full && !(collecting && hdr_busy_reg);
    assign accept      = in_ch.valid && in_ch.ready;
    assign pos_eff     = (pos_reg >= HDR_LAST_IDX) ? HDR_LAST_IDX : pos_reg;

    // byte 11 is checked straight off the input
    assign hdr_ok = (hdr_reg[2][7:3] == 5'd0) && (hdr_reg[4] == 8'h00)
                 && (hdr_reg[5] == 8'h01) && (hdr_reg[6] == 8'h00)
                 && (hdr_reg[7] == 8'h00) && (hdr_reg[8] == 8'h00)
                 && (hdr_reg[9] == 8'h00) && (hdr_reg[10] == 8'h00)
                 && (in_ch.in_byte == 8'h00);

    always_comb
    begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        q_push        = 1'b0;
        q_cmd.flush   = 1'b0;
        q_cmd.last    = in_ch.in_last;
        q_cmd.data    = in_ch.in_byte;
        hdr_busy_next = hdr_busy_reg;
        if (hdr_release)
        begin
            hdr_busy_next = 1'b0;
        end
        if (accept)
        begin
            unique case (mode_reg)
                MODE_COLLECT:
                begin
                    if (pos_eff == HDR_LAST_IDX)
                    begin
                        pos_next = '0;
                        if (hdr_ok)
                        begin
                            q_push        = 1'b1;
                            q_cmd.flush   = 1'b1;
                            hdr_busy_next = 1'b1;
                            mode_next     = in_ch.in_last ? MODE_COLLECT : MODE_PASS;
                        end
                        else
                        begin
                            mode_next = in_ch.in_last ? MODE_COLLECT : MODE_DROP;
                        end
                    end
                    else if (in_ch.in_last)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_eff + 4'd1;
                    end
                end
                MODE_PASS:
                begin
                    q_push = 1'b1;
                    if (in_ch.in_last)
                    begin
                        mode_next = MODE_COLLECT;
                        pos_next  = '0;
                    end
                end
                default:
                begin
                    if (in_ch.in_last)
                    begin
                        mode_next = MODE_COLLECT;
                        pos_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_COLLECT;
            pos_reg      <= '0;
            hdr_busy_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            hdr_busy_reg <= hdr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && collecting)
        begin
            hdr_reg[pos_eff] <= in_ch.in_byte;
        end
    end

    assign hdr               = hdr_reg;
    assign status.hdr_busy   = hdr_busy_reg;
    assign status.collecting = collecting;

endmodule

// ===== rtl/core/cdr_queue.sv =====
module cdr_queue
    import cdr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_MAX);
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/cdr_back.sv =====
module cdr_back
    import cdr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  cmd_t                    q_cmd,
    output logic                    q_pop,
    output logic                    hdr_release,
    input  logic [HDR_LEN-1:0][7:0] hdr,
    input  logic [31:0]             ip,
    cdr_out_if.source               out_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HDR  = 2'd1;
    localparam logic [1:0] ST_REC  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             hdr_last_reg, hdr_last_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hdr_last_next  = hdr_last_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        hdr_release    = 1'b0;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
            out_last_next  = 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        q_pop          = 1'b1;
                        out_valid_next = 1'b1;
                        if (q_cmd.flush)
                        begin
                            out_byte_next = hdr_byte('0, hdr[0]);
                            idx_next      = 4'd1;
                            hdr_last_next = q_cmd.last;
                            state_next    = ST_HDR;
                        end
                        else
                        begin
                            out_byte_next = q_cmd.data;
                            idx_next      = '0;
                            if (q_cmd.last)
                            begin
                                state_next = ST_REC;
                            end
                        end
                    end
                end
                ST_HDR:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = hdr_byte(idx_reg, hdr[idx_reg]);
                    if (idx_reg == HDR_LAST_IDX)
                    begin
                        hdr_release = 1'b1;
                        idx_next    = '0;
                        state_next  = hdr_last_reg ? ST_REC : ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                ST_REC:
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = rec_byte(idx_reg, ip);
                    if (idx_reg == REC_LAST_IDX)
                    begin
                        out_last_next = 1'b1;
                        idx_next      = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            hdr_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hdr_last_reg  <= hdr_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

endmodule

// ===== rtl/core/captive_dns_responder.sv =====
// Channel  Dir  Payload                      Item
// in_ch    in   in_byte[7:0], in_last        one query byte
// out_ch   out  out_byte[7:0], out_last      one response byte
// cfg      in   answer_ipv4_address[31:0]    address write
//
// Input takes one byte per cycle; the front classifies it and queues at most
// one command per byte (QUEUE_DEPTH entries) for the back sequencer.
// The back emits one byte per cycle while out_ch is ready: 12-byte header
// burst, body bytes 1:1, then a 16-byte answer record; output is one
// registered stage. Input stalls when the queue is full, or when a new
// header would start while the back still reads out the previous header,
// until the back releases it on loading the last header byte.
// Reset is asynchronous; no clearing pass, header storage is not reset.
module captive_dns_responder
    import cdr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    cdr_in_if.sink     in_ch,
    cdr_out_if.source  out_ch,
    cdr_cfg_if.sink    cfg
);

    logic [31:0]              ip_reg;
    logic                     q_push;
    logic                     q_pop;
    logic                     q_full;
    logic                     q_empty;
    cmd_t                     push_cmd;
    cmd_t                     head_cmd;
    logic                     hdr_release;
    logic [HDR_LEN-1:0][7:0]  hdr;
    front_status_t            front_status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg <= '0;
        end
        else if (cfg.valid)
        begin
            ip_reg <= cfg.answer_ipv4_address;
        end
    end

    cdr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .hdr_release (hdr_release),
        .hdr         (hdr),
        .status      (front_status)
    );

    cdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    cdr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .hdr_release (hdr_release),
        .hdr         (hdr),
        .ip          (ip_reg),
        .out_ch      (out_ch)
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue pushed while full");

    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_release |-> front_status.hdr_busy)
        else $error("header released while not held");

    a_no_hdr_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> !(front_status.collecting && front_status.hdr_busy))
        else $error("header written while being read out");

endmodule

// ===== tb/cdr_checker.sv =====
`timescale 1ns / 100ps

module cdr_checker
    import cdr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cdr_in_if    in_ch,
    cdr_out_if   out_ch,
    cdr_cfg_if   cfg,
    output int   mismatches,
    output int   pending,
    output int   checked
);

    typedef enum logic [1:0] {
        HDR_GATHER,
        BODY_FORWARD,
        PKT_DISCARD
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last_flag;
    } resp_item_t;

    parse_mode_t  mode;
    int           hdr_pos;
    logic [7:0]   hdr_bytes [HDR_LEN];
    logic [31:0]  answer_ip;
    resp_item_t   resp_q [$];

    initial
    begin
        mismatches = 0;
        checked    = 0;
        pending    = 0;
    end

    function automatic logic header_valid();
        logic ok;
        ok = (hdr_bytes[2][7] == 1'b0) && (hdr_bytes[2][6:3] == 4'd0)
             && (hdr_bytes[4] == 8'h00) && (hdr_bytes[5] == 8'h01);
        for (int i = 6; i < HDR_LEN; i++)
        begin
            if (hdr_bytes[i] != 8'h00)
                ok = 1'b0;
        end
        return ok;
    endfunction

    // A record appended after the last query byte
    function automatic void push_answer();
        logic [7:0] rec [REC_LEN];
        rec = '{8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h04, answer_ip[31:24], answer_ip[23:16],
                answer_ip[15:8], answer_ip[7:0]};
        for (int i = 0; i < REC_LEN; i++)
            resp_q.push_back('{rec[i], i == REC_LEN - 1});
    endfunction

    function automatic void take_query_byte(input logic [7:0] b, input logic fin);
        logic [7:0] h;
        case (mode)
            HDR_GATHER:
            begin
                hdr_bytes[hdr_pos] = b;
                if (hdr_pos == HDR_LEN - 1)
                begin
                    hdr_pos = 0;
                    if (header_valid())
                    begin
                        for (int i = 0; i < HDR_LEN; i++)
                        begin
                            h = hdr_bytes[i];
                            if (i == HDR_FLAGS_IDX)
                                h = h | QR_BIT;
                            else if (i == HDR_ANCOUNT_HI)
                                h = 8'h00;
                            else if (i == HDR_ANCOUNT_LO)
                                h = 8'h01;
                            resp_q.push_back('{h, 1'b0});
                        end
                        if (fin)
                        begin
                            push_answer();
                            mode = HDR_GATHER;
                        end
                        else
                            mode = BODY_FORWARD;
                    end
                    else
                        mode = fin ? HDR_GATHER : PKT_DISCARD;
                end
                else if (fin)
                    hdr_pos = 0;
                else
                    hdr_pos = hdr_pos + 1;
            end
            BODY_FORWARD:
            begin
                resp_q.push_back('{b, 1'b0});
                if (fin)
                begin
                    push_answer();
                    mode = HDR_GATHER;
                    hdr_pos = 0;
                end
            end
            default:
            begin
                if (fin)
                begin
                    mode = HDR_GATHER;
                    hdr_pos = 0;
                end
            end
        endcase
    endfunction

    function automatic void check_response(input logic [7:0] got_byte, input logic got_last);
        resp_item_t want;
        if (resp_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected response item: expected none actual byte %02h last %0b",
                     $time, got_byte, got_last);
            return;
        end
        want = resp_q.pop_front();
        checked++;
        if (got_byte !== want.data)
        begin
            mismatches++;
            $display("%0t: out_byte mismatch: expected %02h actual %02h",
                     $time, want.data, got_byte);
        end
        if (got_last !== want.last_flag)
        begin
            mismatches++;
            $display("%0t: out_last mismatch: expected %0b actual %0b",
                     $time, want.last_flag, got_last);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode      = HDR_GATHER;
            hdr_pos   = 0;
            answer_ip = '0;
            resp_q.delete();
            pending  <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                answer_ip = cfg.answer_ipv4_address;
            if (in_ch.valid && in_ch.ready)
                take_query_byte(in_ch.in_byte, in_ch.in_last);
            if (out_ch.valid && out_ch.ready)
                check_response(out_ch.out_byte, out_ch.out_last);
            pending <= resp_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import cdr_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 13;

    typedef enum int {
        FAULT_QR,
        FAULT_OPCODE,
        FAULT_QDCOUNT_HI,
        FAULT_QDCOUNT_LO,
        FAULT_COUNTS
    } hdr_fault_t;

    logic clk = 1'b0;
    logic rst_n;

    cdr_in_if  in_ch();
    cdr_out_if out_ch();
    cdr_cfg_if cfg_ch();

    int mismatches;
    int pending;
    int checked;

    logic       tx_quiet;
    logic       rx_quiet;
    logic       hold_arm;
    logic       hold_done;
    int         hold_count;
    int         cycle_count;

    logic [7:0] pkt [$];
    int         bytes_sent;
    int         answered;
    int         dropped;
    int         addr_writes;

    captive_dns_responder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    cdr_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response side: random stalls, quiet stretches, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_count   <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_count != 0)
        begin
            out_ch.ready <= 1'b0;
            hold_count   <= hold_count - 1;
        end
        else if (hold_arm && !hold_done)
        begin
            out_ch.ready <= 1'b0;
            hold_count   <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
            out_ch.ready <= rx_quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic send_item(input logic [7:0] b, input logic fin);
        if (!tx_quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= fin;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_pkt();
        for (int i = 0; i < pkt.size(); i++)
            send_item(pkt[i], i == pkt.size() - 1);
        bytes_sent += pkt.size();
    endtask

    task automatic drain_responses();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_address(input logic [31:0] addr);
        cfg_ch.valid               <= 1'b1;
        cfg_ch.answer_ipv4_address <= addr;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        addr_writes++;
    endtask

    task automatic build_good_header();
        pkt.delete();
        pkt.push_back(8'($urandom_range(255)));
        pkt.push_back(8'($urandom_range(255)));
        pkt.push_back(8'($urandom_range(7)));
        pkt.push_back(8'($urandom_range(255)));
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        repeat (6) pkt.push_back(8'h00);
    endtask

    task automatic break_header();
        hdr_fault_t fault;
        logic [7:0] v;
        fault = hdr_fault_t'($urandom_range(4));
        v = pkt[2];
        case (fault)
            FAULT_QR:
            begin
                v = v | QR_BIT;
                if ($urandom_range(1))
                    v[6:3] = 4'($urandom_range(15));
                pkt[2] = v;
            end
            FAULT_OPCODE:
            begin
                v[6:3] = 4'($urandom_range(1, 15));
                pkt[2] = v;
            end
            FAULT_QDCOUNT_HI:
                pkt[4] = 8'($urandom_range(1, 255));
            FAULT_QDCOUNT_LO:
            begin
                v = 8'($urandom_range(255));
                pkt[5] = (v == 8'h01) ? 8'h00 : v;
            end
            default:
                pkt[$urandom_range(6, 11)] = 8'($urandom_range(1, 255));
        endcase
    endtask

    task automatic add_body(input int n);
        repeat (n) pkt.push_back(8'($urandom_range(255)));
    endtask

    task automatic random_phase(input int quota);
        int counted;
        int roll;
        int n;
        counted = 0;
        while (counted < quota)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
            begin
                build_good_header();
                if ($urandom_range(99) < 15)
                    n = 0;
                else if ($urandom_range(99) < 5)
                    n = $urandom_range(25, 64);
                else
                    n = $urandom_range(1, 24);
                add_body(n);
                answered++;
            end
            else if (roll < 80)
            begin
                build_good_header();
                break_header();
                add_body($urandom_range(0, 15));
                dropped++;
            end
            else if (roll < 90)
            begin
                // truncated query, header prefix or garbage
                build_good_header();
                if ($urandom_range(1))
                begin
                    for (int i = 0; i < pkt.size(); i++)
                        pkt[i] = 8'($urandom_range(255));
                end
                n = $urandom_range(1, HDR_LEN - 1);
                while (pkt.size() > n)
                    pkt.delete(pkt.size() - 1);
                dropped++;
            end
            else
            begin
                pkt.delete();
                add_body($urandom_range(HDR_LEN, 30));
                dropped++;
            end
            send_pkt();
            counted += pkt.size();
            if ($urandom_range(9) == 0)
                drain_responses();
        end
    endtask

    initial
    begin
        rst_n                      = 1'b0;
        in_ch.valid                = 1'b0;
        in_ch.in_byte              = 8'h00;
        in_ch.in_last              = 1'b0;
        out_ch.ready               = 1'b0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.answer_ipv4_address = 32'h0;
        tx_quiet                   = 1'b0;
        rx_quiet                   = 1'b0;
        hold_arm                   = 1'b0;
        cycle_count                = 0;
        bytes_sent                 = 0;
        answered                   = 0;
        dropped                    = 0;
        addr_writes                = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, address still at its reset value
        pkt = '{8'hFF};
        send_pkt();
        dropped++;
        pkt = '{8'hFF, 8'hFF, 8'h07, 8'hFF, 8'h00, 8'h01,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_pkt();
        answered++;
        pkt = '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h01,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_pkt();
        dropped++;
        drain_responses();

        write_address(32'hFFFF_FFFF);
        random_phase(45);
        drain_responses();

        write_address(32'h0000_0000);
        hold_arm <= 1'b1;
        random_phase(45);
        drain_responses();

        write_address($urandom());
        tx_quiet <= 1'b1;
        rx_quiet <= 1'b1;
        random_phase(45);
        drain_responses();

        tx_quiet <= 1'b0;
        rx_quiet <= 1'b0;
        write_address($urandom());
        random_phase(45);
        drain_responses();

        $display("covered %0d query bytes: %0d answered and %0d dropped packets",
                 bytes_sent, answered, dropped);
        $display("%0d response bytes compared over %0d address settings",
                 checked, addr_writes + 1);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cdr_pkg.sv
rtl/core/cdr_if.sv
rtl/core/cdr_front.sv
rtl/core/cdr_queue.sv
rtl/core/cdr_back.sv
rtl/core/captive_dns_responder.sv
tb/cdr_checker.sv
tb/testbench.sv
